// ----- src/tpc_pkg.sv -----
// Shared types, register indexes and reset constants for the fan curve controller.
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int TEMP_WIDTH_DEF = 14;
    localparam int PWM_WIDTH      = 7;
    localparam int CFG_IDX_WIDTH  = 2;
    // quotient bits of the ramp division, one per divider step
    localparam int QUOT_BITS      = PWM_WIDTH;
    localparam int STEP_WIDTH     = $clog2(QUOT_BITS);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PWM_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PWM_CEILING = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RAMP_START  = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RAMP_END    = 2'd3;

    localparam logic [PWM_WIDTH-1:0] PWM_FLOOR_RST   = 7'd0;
    localparam logic [PWM_WIDTH-1:0] PWM_CEILING_RST = 7'd100;
    localparam logic [PWM_WIDTH-1:0] RAMP_START_RST  = 7'd0;
    localparam logic [PWM_WIDTH-1:0] RAMP_END_RST    = 7'd100;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLASSIFY = 6'b000010,
        S_MUL      = 6'b000100,
        S_SUM      = 6'b001000,
        S_DIV      = 6'b010000,
        S_FINISH   = 6'b100000
    } t_state;

    typedef struct packed {
        logic accept;
        logic classify;
        logic mul;
        logic sum;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_needed;
        logic direct;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- src/tpc_ctrl.sv -----
// Sequencer for one poll word: update, classify, multiply, sum, divide, deliver.
`timescale 1ns / 1ps

module tpc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  tpc_pkg::t_dp_status  i_status,
    output tpc_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);
    import tpc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                // no command this word: go straight to delivery
                if (!i_status.cmd_needed) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.classify = 1'b1;
                    n_state = i_status.direct ? S_FINISH : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/tpc_dp.sv -----
// Datapath: mode and set-point state, curve registers, ramp multiply and divider.
`timescale 1ns / 1ps

module tpc_dp #(
    parameter int TEMP_WIDTH = tpc_pkg::TEMP_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tpc_pkg::t_dp_cmd                      i_cmd,
    output tpc_pkg::t_dp_status                   o_status,
    input  logic                                  i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [tpc_pkg::PWM_WIDTH-1:0]         i_cfg_data,
    input  logic                                  i_reading_valid,
    input  logic signed [TEMP_WIDTH-1:0]          i_temperature,
    input  logic                                  i_mode_button,
    input  logic                                  i_low_button,
    input  logic                                  i_high_button,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic [tpc_pkg::PWM_WIDTH-1:0]         o_pwm_command,
    output logic                                  o_command_valid,
    output logic                                  o_operational,
    output logic signed [TEMP_WIDTH-1:0]          o_low_set_point,
    output logic signed [TEMP_WIDTH-1:0]          o_high_set_point,
    output logic signed [TEMP_WIDTH-1:0]          o_held_temperature
);
    import tpc_pkg::*;

    // products are PWM x span wide, the numerator one bit more
    localparam int PW = TEMP_WIDTH + PWM_WIDTH;
    localparam int NW = PW + 1;

    logic [PWM_WIDTH-1:0] r_floor, r_ceiling, r_start, r_end;

    logic                         r_mode, r_mb_last, r_pending, r_cmd_needed;
    logic signed [TEMP_WIDTH-1:0] r_latest, r_low, r_high;

    logic [TEMP_WIDTH-1:0]  r_span, r_below, r_above;
    logic [PW-1:0]          r_prod_a, r_prod_b;
    logic [NW-1:0]          r_rem;
    logic [QUOT_BITS-1:0]   r_quot;
    logic [STEP_WIDTH-1:0]  r_step;
    logic [PWM_WIDTH-1:0]   r_cmd;

    logic                         r_out_valid;
    logic [PWM_WIDTH-1:0]         r_out_pwm;
    logic                         r_out_cmd_valid;
    logic                         r_out_mode;
    logic signed [TEMP_WIDTH-1:0] r_out_low, r_out_high, r_out_held;

    // accept-cycle state update
    logic                         n_mode, n_pend_any;
    logic signed [TEMP_WIDTH-1:0] n_latest, n_low_cand, n_high_cand;

    always_comb begin
        n_latest    = i_reading_valid ? i_temperature : r_latest;
        n_mode      = r_mode ^ (i_mode_button & ~r_mb_last);
        n_pend_any  = r_pending | i_reading_valid;
        n_low_cand  = i_low_button  ? n_latest : r_low;
        n_high_cand = i_high_button ? n_latest : r_high;
    end

    // classification against the set points
    logic signed [TEMP_WIDTH:0] w_span, w_below, w_above;
    logic                       w_lt_low, w_gt_high, w_direct;
    logic [PWM_WIDTH-1:0]       w_direct_val;

    always_comb begin
        w_span    = {r_high[TEMP_WIDTH-1], r_high} - {r_low[TEMP_WIDTH-1], r_low};
        w_below   = {r_high[TEMP_WIDTH-1], r_high} - {r_latest[TEMP_WIDTH-1], r_latest};
        w_above   = {r_latest[TEMP_WIDTH-1], r_latest} - {r_low[TEMP_WIDTH-1], r_low};
        w_lt_low  = (r_latest < r_low);
        w_gt_high = (r_latest > r_high);
        w_direct  = w_lt_low | w_gt_high | (r_low == r_high);
        if (w_lt_low) begin
            w_direct_val = r_floor;
        end else if (w_gt_high) begin
            w_direct_val = r_ceiling;
        end else begin
            w_direct_val = r_start;
        end
    end

    // restoring divider: one quotient bit per step, quotient fits PWM width
    logic [NW-1:0]        w_trial;
    logic                 w_fits;
    logic [QUOT_BITS-1:0] w_quot_next;

    always_comb begin
        w_trial     = {{(NW-TEMP_WIDTH){1'b0}}, r_span} << r_step;
        w_fits      = (r_rem >= w_trial);
        w_quot_next = r_quot;
        w_quot_next[r_step] = w_fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= PWM_FLOOR_RST;
            r_ceiling <= PWM_CEILING_RST;
            r_start   <= RAMP_START_RST;
            r_end     <= RAMP_END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PWM_FLOOR:   r_floor   <= i_cfg_data;
                CFG_PWM_CEILING: r_ceiling <= i_cfg_data;
                CFG_RAMP_START:  r_start   <= i_cfg_data;
                CFG_RAMP_END:    r_end     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_mb_last    <= 1'b0;
            r_pending    <= 1'b0;
            r_cmd_needed <= 1'b0;
            r_latest     <= '0;
            r_low        <= '0;
            r_high       <= '0;
        end else if (i_cmd.accept) begin
            r_mode       <= n_mode;
            r_mb_last    <= i_mode_button;
            r_latest     <= n_latest;
            r_pending    <= n_pend_any & ~n_mode;
            r_cmd_needed <= n_pend_any & n_mode;
            if (!n_mode) begin
                // inverted set points clear both
                if (n_high_cand < n_low_cand) begin
                    r_low  <= '0;
                    r_high <= '0;
                end else begin
                    r_low  <= n_low_cand;
                    r_high <= n_high_cand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= '0;
        end else if (i_cmd.classify) begin
            r_span  <= w_span[TEMP_WIDTH-1:0];
            r_below <= w_below[TEMP_WIDTH-1:0];
            r_above <= w_above[TEMP_WIDTH-1:0];
            r_cmd   <= w_direct_val;
        end else if (i_cmd.mul) begin
            r_prod_a <= {{(PW-PWM_WIDTH){1'b0}}, r_start} * {{(PW-TEMP_WIDTH){1'b0}}, r_below};
            r_prod_b <= {{(PW-PWM_WIDTH){1'b0}}, r_end} * {{(PW-TEMP_WIDTH){1'b0}}, r_above};
        end else if (i_cmd.sum) begin
            r_rem  <= {1'b0, r_prod_a} + {1'b0, r_prod_b};
            r_quot <= '0;
            r_step <= STEP_WIDTH'(QUOT_BITS - 1);
        end else if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= r_rem - w_trial;
            end
            r_quot <= w_quot_next;
            r_step <= r_step - 1'b1;
            r_cmd  <= w_quot_next;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // state fields are captured too, the next word may update them while this one waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pwm       <= r_cmd;
            r_out_cmd_valid <= r_cmd_needed;
            r_out_mode      <= r_mode;
            r_out_low       <= r_low;
            r_out_high      <= r_high;
            r_out_held      <= r_latest;
        end
    end

    assign o_status.cmd_needed = r_cmd_needed;
    assign o_status.direct     = w_direct;
    assign o_status.div_last   = (r_step == '0);
    assign o_status.out_free   = ~r_out_valid | ~i_stall;

    assign o_valid            = r_out_valid;
    assign o_pwm_command      = r_out_pwm;
    assign o_command_valid    = r_out_cmd_valid;
    assign o_operational      = r_out_mode;
    assign o_low_set_point    = r_out_low;
    assign o_high_set_point   = r_out_high;
    assign o_held_temperature = r_out_held;

endmodule

// ----- src/temperature_to_pwm_curve_controller.sv -----
// Top level of the temperature to PWM fan curve controller.
// Usage:
//   Input channel (i_valid / o_stall) takes one poll word: an optional new
//   reading, the temperature and three button levels. Output channel
//   (o_valid / i_stall) returns exactly one word per poll word: duty command,
//   command flag, mode, both set points and the held reading.
//   Steps: accept, classify and deliver when no command is issued, the reading
//   falls outside the ramp or the span is zero; for a ramp value classify,
//   multiply, sum, 7 steps of the restoring divider, then deliver. One word
//   is worked on at a time, and the next word can be accepted in the cycle
//   after delivery.
//   o_stall is high while a word is being worked on. A result waiting under
//   i_stall does not block the next accept; that word then waits in its
//   final cycle until the output register frees up.
//   Reset (synchronous, active low) clears mode, set points and held reading,
//   and loads floor 0, ceiling 100, ramp start 0, ramp end 100.
//   Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
`timescale 1ns / 1ps

module temperature_to_pwm_curve_controller #(
    parameter int TEMP_WIDTH = tpc_pkg::TEMP_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [tpc_pkg::PWM_WIDTH-1:0]      i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_reading_valid,
    input  logic signed [TEMP_WIDTH-1:0]       i_temperature,
    input  logic                               i_mode_button,
    input  logic                               i_low_button,
    input  logic                               i_high_button,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [tpc_pkg::PWM_WIDTH-1:0]      o_pwm_command,
    output logic                               o_command_valid,
    output logic                               o_operational,
    output logic signed [TEMP_WIDTH-1:0]       o_low_set_point,
    output logic signed [TEMP_WIDTH-1:0]       o_high_set_point,
    output logic signed [TEMP_WIDTH-1:0]       o_held_temperature
);
    import tpc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_busy;

    tpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    tpc_dp #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_reading_valid    (i_reading_valid),
        .i_temperature      (i_temperature),
        .i_mode_button      (i_mode_button),
        .i_low_button       (i_low_button),
        .i_high_button      (i_high_button),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_pwm_command      (o_pwm_command),
        .o_command_valid    (o_command_valid),
        .o_operational      (o_operational),
        .o_low_set_point    (o_low_set_point),
        .o_high_set_point   (o_high_set_point),
        .o_held_temperature (o_held_temperature)
    );

    assign o_stall = w_busy;

    // a duty command only comes out of operational mode
    a_cmd_operational: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_command_valid) |-> o_operational)
        else $error("command issued in configuration mode");

    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_command_valid) |-> (o_pwm_command == '0))
        else $error("nonzero duty without command");

    a_points_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_high_set_point >= o_low_set_point))
        else $error("set points out of order");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("not busy after accepting a word");

endmodule

// ----- dv/tb_temperature_to_pwm_curve_controller.sv -----
// Self-checking testbench for the temperature to PWM fan curve controller.
`timescale 1ns / 1ps

module tb_temperature_to_pwm_curve_controller;
    import tpc_pkg::*;

    localparam int TW            = TEMP_WIDTH_DEF;
    localparam int TEMP_MIN      = -(1 << (TW - 1));
    localparam int TEMP_MAX      = (1 << (TW - 1)) - 1;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 150;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        logic                 reading_valid;
        logic signed [TW-1:0] temperature;
        logic                 mode_button;
        logic                 low_button;
        logic                 high_button;
    } poll_t;

    typedef struct {
        logic [PWM_WIDTH-1:0] pwm;
        logic                 cmd_valid;
        logic                 operational;
        logic signed [TW-1:0] low_sp;
        logic signed [TW-1:0] high_sp;
        logic signed [TW-1:0] held;
    } duty_word_t;

    // Fan curve predictor plus the queue of duty words it expects back.
    class fan_curve_scoreboard;
        logic [PWM_WIDTH-1:0] floor_duty, ceiling_duty, start_duty, end_duty;
        bit                   mode_op, mode_btn_last, reading_waiting;
        int                   held_temp, low_pt, high_pt;
        duty_word_t           expected_q[$];
        int                   words, checked, commands, ramp_cmds, clears, errors;

        function new();
            words = 0;
            checked = 0;
            commands = 0;
            ramp_cmds = 0;
            clears = 0;
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            floor_duty      = PWM_FLOOR_RST;
            ceiling_duty    = PWM_CEILING_RST;
            start_duty      = RAMP_START_RST;
            end_duty        = RAMP_END_RST;
            mode_op         = 0;
            mode_btn_last   = 0;
            reading_waiting = 0;
            held_temp       = 0;
            low_pt          = 0;
            high_pt         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [PWM_WIDTH-1:0] val);
            case (idx)
                CFG_PWM_FLOOR:   floor_duty = val;
                CFG_PWM_CEILING: ceiling_duty = val;
                CFG_RAMP_START:  start_duty = val;
                CFG_RAMP_END:    end_duty = val;
                default: ;
            endcase
        endfunction

        function void note_poll(poll_t p);
            duty_word_t exp;
            longint     span, num;
            logic [PWM_WIDTH-1:0] duty;
            bit         issued;
            duty   = '0;
            issued = 0;
            words++;
            if (p.reading_valid) begin
                held_temp       = p.temperature;
                reading_waiting = 1;
            end
            if (p.mode_button && !mode_btn_last)
                mode_op = !mode_op;
            mode_btn_last = p.mode_button;
            if (!mode_op) begin
                if (p.low_button)
                    low_pt = held_temp;
                if (p.high_button)
                    high_pt = held_temp;
                if (high_pt < low_pt) begin
                    low_pt  = 0;
                    high_pt = 0;
                    clears++;
                end
            end else if (reading_waiting) begin
                reading_waiting = 0;
                issued = 1;
                commands++;
                if (held_temp < low_pt) begin
                    duty = floor_duty;
                end else if (held_temp > high_pt) begin
                    duty = ceiling_duty;
                end else begin
                    ramp_cmds++;
                    span = longint'(high_pt) - longint'(low_pt);
                    if (span <= 0) begin
                        duty = start_duty;
                    end else begin
                        // weighted mix of both end duties, floor division
                        num = longint'(start_duty) * (longint'(high_pt) - held_temp)
                            + longint'(end_duty) * (longint'(held_temp) - low_pt);
                        duty = PWM_WIDTH'(num / span);
                    end
                end
            end
            exp.pwm         = duty;
            exp.cmd_valid   = issued;
            exp.operational = mode_op;
            exp.low_sp      = TW'(low_pt);
            exp.high_sp     = TW'(high_pt);
            exp.held        = TW'(held_temp);
            expected_q.push_back(exp);
        endfunction

        function void check_field(string name, logic signed [31:0] exp_v,
                                  logic signed [31:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(duty_word_t got);
            duty_word_t exp;
            if (expected_q.size() == 0) begin
                $error("duty word arrived with nothing expected");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            check_field("pwm_command", exp.pwm, got.pwm);
            check_field("command_valid", exp.cmd_valid, got.cmd_valid);
            check_field("operational", exp.operational, got.operational);
            check_field("low_set_point", exp.low_sp, got.low_sp);
            check_field("high_set_point", exp.high_sp, got.high_sp);
            check_field("held_temperature", exp.held, got.held);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void finish_check();
            if (expected_q.size() != 0) begin
                $error("%0d duty words never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [PWM_WIDTH-1:0]     i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_reading_valid;
    logic signed [TW-1:0]     i_temperature;
    logic                     i_mode_button;
    logic                     i_low_button;
    logic                     i_high_button;
    logic                     o_valid;
    logic                     i_stall;
    logic [PWM_WIDTH-1:0]     o_pwm_command;
    logic                     o_command_valid;
    logic                     o_operational;
    logic signed [TW-1:0]     o_low_set_point;
    logic signed [TW-1:0]     o_high_set_point;
    logic signed [TW-1:0]     o_held_temperature;

    fan_curve_scoreboard sb;
    int                  idle_cycles;
    int                  cfg_writes;
    bit                  held_off;

    temperature_to_pwm_curve_controller #(
        .TEMP_WIDTH(TW)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_reading_valid    (i_reading_valid),
        .i_temperature      (i_temperature),
        .i_mode_button      (i_mode_button),
        .i_low_button       (i_low_button),
        .i_high_button      (i_high_button),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_pwm_command      (o_pwm_command),
        .o_command_valid    (o_command_valid),
        .o_operational      (o_operational),
        .o_low_set_point    (o_low_set_point),
        .o_high_set_point   (o_high_set_point),
        .o_held_temperature (o_held_temperature)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int clip_temp(int t);
        if (t < TEMP_MIN)
            return TEMP_MIN;
        if (t > TEMP_MAX)
            return TEMP_MAX;
        return t;
    endfunction

    function automatic int rand_temp();
        case ($urandom_range(15))
            0: return TEMP_MIN;
            1: return TEMP_MAX;
            2: return 0;
            3: return int'($urandom_range(0, 200)) - 100;
            default: return int'($urandom_range(0, 16383)) + TEMP_MIN;
        endcase
    endfunction

    function automatic logic [PWM_WIDTH-1:0] rand_duty();
        case ($urandom_range(9))
            0: return 7'd0;
            1: return 7'd100;
            2: return 7'd127;
            default: return PWM_WIDTH'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic poll_t make_poll(bit rv, int t, bit mb, bit lb, bit hb);
        poll_t p;
        p.reading_valid = rv;
        p.temperature   = t[TW-1:0];
        p.mode_button   = mb;
        p.low_button    = lb;
        p.high_button   = hb;
        return p;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(poll_t w);
        while (!(sb.words >= 700 && sb.words < 950) && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_reading_valid <= w.reading_valid;
        i_temperature   <= w.temperature;
        i_mode_button   <= w.mode_button;
        i_low_button    <= w.low_button;
        i_high_button   <= w.high_button;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_poll(w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [PWM_WIDTH-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic load_curve(logic [PWM_WIDTH-1:0] fl, logic [PWM_WIDTH-1:0] ce,
                              logic [PWM_WIDTH-1:0] st, logic [PWM_WIDTH-1:0] en);
        write_reg(CFG_PWM_FLOOR, fl);
        write_reg(CFG_PWM_CEILING, ce);
        write_reg(CFG_RAMP_START, st);
        write_reg(CFG_RAMP_END, en);
    endtask

    // Config mode, capture set points, go operational, then a run of readings
    // around the captured span.
    task automatic run_episode();
        int lo, hi, span, margin, n;
        if (sb.mode_op) begin
            if (sb.mode_btn_last)
                send_word(make_poll(0, rand_temp(), 0, 0, 0));
            send_word(make_poll($urandom_range(1), rand_temp(), 1, 0, 0));
        end
        lo = rand_temp();
        case ($urandom_range(9))
            0: span = 0;
            1: span = -int'($urandom_range(1, 300));
            2: span = $urandom_range(1, 16383);
            default: span = $urandom_range(1, 400);
        endcase
        hi = clip_temp(lo + span);
        if ($urandom_range(3) == 0) begin
            send_word(make_poll(1, lo, 0, 1, 0));
        end else begin
            send_word(make_poll(1, lo, 0, 1, 1));
        end
        send_word(make_poll(1, hi, 0, 0, 1));
        span   = (hi > lo) ? hi - lo : lo - hi;
        margin = span / 4 + 2;
        lo     = (hi < lo) ? hi : lo;
        send_word(make_poll($urandom_range(1),
                            clip_temp(lo - margin + int'($urandom_range(0, span + 2 * margin))),
                            1, $urandom_range(1), $urandom_range(1)));
        n = $urandom_range(4, 20);
        repeat (n) begin
            send_word(make_poll($urandom_range(9) != 0,
                                clip_temp(lo - margin
                                          + int'($urandom_range(0, span + 2 * margin))),
                                0, $urandom_range(9) == 0, $urandom_range(9) == 0));
        end
    endtask

    // Receiving side: random stalls, one long hold-off, checks every word.
    initial begin
        int hold;
        hold     = 0;
        held_off = 0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && sb != null && sb.checked >= 400) begin
                held_off = 1;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= !(sb != null && sb.checked >= 700 && sb.checked < 950)
                           && ($urandom_range(99) < 9);
            end
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                duty_word_t got;
                got.pwm         = o_pwm_command;
                got.cmd_valid   = o_command_valid;
                got.operational = o_operational;
                got.low_sp      = o_low_set_point;
                got.high_sp     = o_high_set_point;
                got.held        = o_held_temperature;
                sb.check_result(got);
            end
        end
    end

    // Stops the run when neither channel moves for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                break;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb_temperature_to_pwm_curve_controller: done, errors");
        $finish;
    end

    initial begin
        sb              = new();
        cfg_writes      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_PWM_FLOOR;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_reading_valid = 1'b0;
        i_temperature   = '0;
        i_mode_button   = 1'b0;
        i_low_button    = 1'b0;
        i_high_button   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: full-scale set points, pending reading across the mode
        // switch, captures ignored when operational, zero span.
        load_curve(7'd5, 7'd95, 7'd10, 7'd90);
        send_word(make_poll(1, TEMP_MIN, 0, 0, 0));
        send_word(make_poll(0, TEMP_MAX, 0, 1, 0));
        send_word(make_poll(1, TEMP_MAX, 0, 0, 1));
        send_word(make_poll(0, 0, 1, 0, 0));
        send_word(make_poll(0, 0, 0, 0, 0));
        send_word(make_poll(1, 0, 0, 0, 0));
        send_word(make_poll(1, TEMP_MIN, 0, 1, 1));
        send_word(make_poll(1, 100, 1, 0, 0));
        send_word(make_poll(0, 0, 0, 1, 1));
        send_word(make_poll(0, 0, 1, 0, 0));
        send_word(make_poll(1, 50, 0, 0, 0));
        send_word(make_poll(1, 150, 0, 0, 0));
        settle();

        // Directed: descending ramp, duties above 100, set point clearing.
        load_curve(7'd100, 7'd127, 7'd127, 7'd0);
        send_word(make_poll(1, 0, 1, 1, 0));
        send_word(make_poll(1, 3, 0, 0, 1));
        send_word(make_poll(1, 1000, 0, 1, 0));
        send_word(make_poll(1, -30, 0, 1, 0));
        send_word(make_poll(1, 33, 0, 0, 1));
        send_word(make_poll(1, 10, 1, 0, 0));
        send_word(make_poll(1, -31, 0, 0, 0));
        send_word(make_poll(1, 34, 0, 0, 0));
        send_word(make_poll(1, 33, 0, 0, 0));
        send_word(make_poll(1, -30, 0, 1, 1));
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            int target;
            target = sb.words + PHASE_WORDS;
            if (ph == 0)
                load_curve(7'd0, 7'd0, 7'd0, 7'd0);
            else if (ph == 1)
                load_curve(7'd127, 7'd127, 7'd127, 7'd127);
            else
                load_curve(rand_duty(), rand_duty(), rand_duty(), rand_duty());
            while (sb.words < target) begin
                if ($urandom_range(99) < 12)
                    send_word(make_poll($urandom_range(1), rand_temp(), $urandom_range(1),
                                        $urandom_range(1), $urandom_range(1)));
                else
                    run_episode();
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        sb.finish_check();
        $display("covered %0d poll words and %0d register writes over %0d curve settings",
                 sb.words, cfg_writes, PHASES + 2);
        $display("%0d duty commands (%0d inside the span), %0d set point clears",
                 sb.commands, sb.ramp_cmds, sb.clears);
        if (sb.errors == 0)
            $display("tb_temperature_to_pwm_curve_controller: done, clean");
        else
            $display("tb_temperature_to_pwm_curve_controller: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tpc_pkg.sv
src/tpc_ctrl.sv
src/tpc_dp.sv
src/temperature_to_pwm_curve_controller.sv
dv/tb_temperature_to_pwm_curve_controller.sv
